>>> rtl/tsfm_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter and map: shared types and constants
// Payload structs, register indexes, scan group codes and reset values.
// ----------------------------------------------------------------------------
package tsfm_pkg;

   // Default build values for the top-level parameters.
   localparam int GROUP_SIZE_DEF = 5;
   localparam int ADC_BITS_DEF   = 12;

   // Fixed field widths.
   localparam int SAMPLE_W   = 12;
   localparam int POS_W      = 16;
   localparam int GAIN_W     = 32;
   localparam int OFFSET_W   = 16;
   localparam int LIMIT_W    = 12;
   localparam int FRAC_BITS  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_RAW_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AGREE_LIMIT = 3'd5;

   // Reset and special values.
   localparam logic [LIMIT_W-1:0] AGREE_LIMIT_RST = 12'd50;
   localparam logic [POS_W-1:0]   POS_IDLE        = 16'hFFFF;
   localparam logic [POS_W-1:0]   POS_MAX         = 16'hFFFF;

   // Input operation codes.
   localparam logic OP_PEN_UP = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Sample groups of one scan, in arrival order.
   typedef enum logic [1:0] {
      GRP_X0 = 2'd0,
      GRP_Y0 = 2'd1,
      GRP_X1 = 2'd2,
      GRP_Y1 = 2'd3
   } grp_type;

   // Tag that travels with a finished group mean.
   typedef struct packed {
      logic    valid;
      grp_type grp;
   } mean_tag_type;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic             pressed;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] press_x;
      logic [POS_W-1:0] press_y;
      logic             readings_agreed;
   } rsp_type;

endpackage

>>> rtl/tsfm_group_filter.sv
// ----------------------------------------------------------------------------
// Touch sample filter: group accumulator and trimmed mean
// Keeps the running sum, minimum and maximum of a sample group and, once the
// group closes, registers its trimmed mean (sum - min - max) / (N - 2).
// ----------------------------------------------------------------------------
module tsfm_group_filter #(
   parameter int GROUP_SIZE = tsfm_pkg::GROUP_SIZE_DEF,
   parameter int ADC_BITS   = tsfm_pkg::ADC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sample_en,
   input  logic                   clear,
   input  logic [ADC_BITS-1:0]    sample,
   output logic                   scan_end,
   output tsfm_pkg::mean_tag_type mean_tag,
   output logic [ADC_BITS-1:0]    mean
);
   import tsfm_pkg::*;

   localparam int POS_CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int SUM_W     = $clog2(GROUP_SIZE * ((1 << ADC_BITS) - 1) + 1);
   // Division by GROUP_SIZE-2 as a multiply by a rounded-up reciprocal; the
   // shift covers every trimmed sum below 2**SUM_W exactly.
   localparam int DIVISOR   = GROUP_SIZE - 2;
   localparam int DIV_LOG   = $clog2(DIVISOR);
   localparam int DIV_SHIFT = SUM_W + DIV_LOG;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int MUL_W     = $clog2(DIV_MULT + 1);
   localparam int PROD_W    = SUM_W + MUL_W;

   logic [POS_CNT_W-1:0] pos_ff;
   grp_type              grp_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [ADC_BITS-1:0]  min_ff, min_in;
   logic [ADC_BITS-1:0]  max_ff, max_in;
   mean_tag_type         done_ff;
   mean_tag_type         mean_tag_ff;
   logic [ADC_BITS-1:0]  mean_ff, mean_in;
   logic                 first, last;
   logic [SUM_W-1:0]     trim;
   logic [PROD_W-1:0]    prod;

   // Running sum, minimum and maximum including the current sample.
   always_comb begin
      first    = (pos_ff == '0);
      last     = (pos_ff == POS_CNT_W'(GROUP_SIZE - 1));
      sum_in   = first ? SUM_W'(sample) : sum_ff + SUM_W'(sample);
      min_in   = (first || sample < min_ff) ? sample : min_ff;
      max_in   = (first || sample > max_ff) ? sample : max_ff;
      scan_end = sample_en && last && (grp_ff == GRP_Y1);
   end

   // Trimmed mean of the group that closed in the previous cycle.
   always_comb begin
      trim    = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
      prod    = PROD_W'(trim) * PROD_W'(DIV_MULT);
      mean_in = prod[DIV_SHIFT +: ADC_BITS];
   end

   // Group position, group index and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         grp_ff  <= GRP_X0;
         sum_ff  <= '0;
         done_ff <= '0;
      end else begin
         done_ff.valid <= sample_en && last;
         done_ff.grp   <= grp_ff;
         if (clear) begin
            pos_ff <= '0;
            grp_ff <= GRP_X0;
            sum_ff <= '0;
         end else if (sample_en) begin
            sum_ff <= sum_in;
            if (last) begin
               pos_ff <= '0;
               grp_ff <= grp_type'(2'(grp_ff) + 2'd1);
            end else begin
               pos_ff <= pos_ff + POS_CNT_W'(1);
            end
         end
      end
   end

   // Minimum and maximum need no reset: the first sample of a group loads them.
   always_ff @(posedge clock) begin
      if (sample_en) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // Mean result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_tag_ff <= '0;
      end else begin
         mean_tag_ff <= done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ff.valid) begin
         mean_ff <= mean_in;
      end
   end

   assign mean_tag = mean_tag_ff;
   assign mean     = mean_ff;

endmodule

>>> rtl/tsfm_axis_map.sv
// ----------------------------------------------------------------------------
// Touch sample filter: axis mapping
// Registers value * gain, then adds the offset scaled to the gain's fraction
// bits, drops the fraction and clamps the result to 0..65535.
// ----------------------------------------------------------------------------
module tsfm_axis_map #(
   parameter int ADC_BITS = tsfm_pkg::ADC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [ADC_BITS-1:0]                  value,
   input  logic signed [tsfm_pkg::GAIN_W-1:0]   gain,
   input  logic signed [tsfm_pkg::OFFSET_W-1:0] offset,
   output logic [tsfm_pkg::POS_W-1:0]           pos
);
   import tsfm_pkg::*;

   localparam int PROD_W  = ADC_BITS + 1 + GAIN_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int WHOLE_W = ACC_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc;
   logic [WHOLE_W-1:0]       whole;

   // Product register.
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'($signed({1'b0, value})) * PROD_W'(gain);
      end
   end

   // Offset, truncation and clamp.
   always_comb begin
      acc   = ACC_W'(prod_ff) + (ACC_W'(offset) <<< FRAC_BITS);
      whole = acc[ACC_W-1:FRAC_BITS];
      if (acc[ACC_W-1]) begin
         pos = '0;
      end else if (|whole[WHOLE_W-1:POS_W]) begin
         pos = POS_MAX;
      end else begin
         pos = whole[POS_W-1:0];
      end
   end

endmodule

>>> rtl/touch_sample_filter_and_map.sv
// ----------------------------------------------------------------------------
// Touch sample filter and map: top level
// Trimmed-mean filtering of touch ADC samples, agreement check, averaging,
// linear screen mapping and pen-down / press tracking.
// ----------------------------------------------------------------------------
// A scan is four groups of GROUP_SIZE samples (X, Y, X, Y). Samples are taken
// one per clock unless input is held off; a sample that does not finish a scan
// gives no result. The scan's last sample holds off input while the trimmed
// mean, agreement check, mapping multiply and final clamp run through their
// pipeline registers, until the result is loaded. A pen-up transfer is taken
// when input is not held off and the result register is free or being emptied
// in that cycle, and its result appears in the next cycle. Results wait in a
// one-entry output register; samples keep flowing while it is full. The user
// writes configuration only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module touch_sample_filter_and_map #(
   parameter int GROUP_SIZE = tsfm_pkg::GROUP_SIZE_DEF,
   parameter int ADC_BITS   = tsfm_pkg::ADC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tsfm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tsfm_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [tsfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsfm_pkg::*;

   localparam int CMP_W = (ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W;

   // Configuration registers.
   logic                       raw_mode_ff;
   logic signed [GAIN_W-1:0]   x_gain_ff, y_gain_ff;
   logic signed [OFFSET_W-1:0] x_offset_ff, y_offset_ff;
   logic [LIMIT_W-1:0]         agree_limit_ff;

   // Handshake and control.
   logic                req_fire, sample_fire, pen_up_fire, out_free, finish, scan_end;
   logic                busy_ff;
   logic [ADC_BITS-1:0] sample;

   // Group filter outputs and stored means.
   mean_tag_type        mean_tag;
   logic [ADC_BITS-1:0] mean;
   logic [ADC_BITS-1:0] first_x_ff, first_y_ff, second_x_ff;

   // Agreement stage.
   logic                agree_in;
   logic [ADC_BITS:0]   sum_x, sum_y;
   logic [ADC_BITS-1:0] diff_x, diff_y;
   logic                s4_valid_ff, s4_agree_ff;
   logic [ADC_BITS-1:0] s4_ax_ff, s4_ay_ff;

   // Mapping and final stage.
   logic                s5_valid_ff, s5_agree_ff;
   logic [ADC_BITS-1:0] s5_ax_ff, s5_ay_ff;
   logic [POS_W-1:0]    map_x, map_y, new_x, new_y;

   // Tracking state and result register.
   logic             pen_held_ff;
   logic [POS_W-1:0] cur_x_ff, cur_y_ff, down_x_ff, down_y_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Input acceptance: a pen-up transfer needs the result register.
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = !busy_ff && ((req_data.op == OP_SAMPLE) || out_free);
      req_fire    = req_valid && req_ready;
      sample_fire = req_fire && (req_data.op == OP_SAMPLE);
      pen_up_fire = req_fire && (req_data.op == OP_PEN_UP);
      sample      = ADC_BITS'(req_data.sample);
      finish      = s5_valid_ff && out_free;
   end

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff    <= 1'b0;
         x_gain_ff      <= '0;
         x_offset_ff    <= '0;
         y_gain_ff      <= '0;
         y_offset_ff    <= '0;
         agree_limit_ff <= AGREE_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_RAW_MODE:    raw_mode_ff    <= csr_wdata[0];
            REG_X_GAIN:      x_gain_ff      <= csr_wdata[GAIN_W-1:0];
            REG_X_OFFSET:    x_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            REG_Y_GAIN:      y_gain_ff      <= csr_wdata[GAIN_W-1:0];
            REG_Y_OFFSET:    y_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            REG_AGREE_LIMIT: agree_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Group accumulation and trimmed mean.
   tsfm_group_filter #(
      .GROUP_SIZE (GROUP_SIZE),
      .ADC_BITS   (ADC_BITS)
   ) u_group_filter (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_fire),
      .clear     (pen_up_fire),
      .sample    (sample),
      .scan_end  (scan_end),
      .mean_tag  (mean_tag),
      .mean      (mean)
   );

   // Input is held off from the scan's last sample until its result is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (scan_end) begin
         busy_ff <= 1'b1;
      end else if (finish) begin
         busy_ff <= 1'b0;
      end
   end

   // Store the means of the first three groups.
   always_ff @(posedge clock) begin
      if (mean_tag.valid) begin
         case (mean_tag.grp)
            GRP_X0: first_x_ff  <= mean;
            GRP_Y0: first_y_ff  <= mean;
            GRP_X1: second_x_ff <= mean;
            default: begin
            end
         endcase
      end
   end

   // Agreement check and averaging once the last group's mean is ready.
   always_comb begin
      diff_x   = (first_x_ff >= second_x_ff) ? first_x_ff - second_x_ff
                                             : second_x_ff - first_x_ff;
      diff_y   = (first_y_ff >= mean) ? first_y_ff - mean : mean - first_y_ff;
      agree_in = (CMP_W'(diff_x) < CMP_W'(agree_limit_ff)) &&
                 (CMP_W'(diff_y) < CMP_W'(agree_limit_ff));
      sum_x    = {1'b0, first_x_ff} + {1'b0, second_x_ff};
      sum_y    = {1'b0, first_y_ff} + {1'b0, mean};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= mean_tag.valid && (mean_tag.grp == GRP_Y1);
         if (s4_valid_ff) begin
            s5_valid_ff <= 1'b1;
         end else if (finish) begin
            s5_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mean_tag.valid && (mean_tag.grp == GRP_Y1)) begin
         s4_agree_ff <= agree_in;
         s4_ax_ff    <= sum_x[ADC_BITS:1];
         s4_ay_ff    <= sum_y[ADC_BITS:1];
      end
      if (s4_valid_ff) begin
         s5_agree_ff <= s4_agree_ff;
         s5_ax_ff    <= s4_ax_ff;
         s5_ay_ff    <= s4_ay_ff;
      end
   end

   // Screen mapping of both axes.
   tsfm_axis_map #(
      .ADC_BITS (ADC_BITS)
   ) u_map_x (
      .clock  (clock),
      .load   (s4_valid_ff),
      .value  (s4_ax_ff),
      .gain   (x_gain_ff),
      .offset (x_offset_ff),
      .pos    (map_x)
   );

   tsfm_axis_map #(
      .ADC_BITS (ADC_BITS)
   ) u_map_y (
      .clock  (clock),
      .load   (s4_valid_ff),
      .value  (s4_ay_ff),
      .gain   (y_gain_ff),
      .offset (y_offset_ff),
      .pos    (map_y)
   );

   // New position and result payload.
   always_comb begin
      new_x = cur_x_ff;
      new_y = cur_y_ff;
      if (s5_agree_ff) begin
         new_x = raw_mode_ff ? POS_W'(s5_ax_ff) : map_x;
         new_y = raw_mode_ff ? POS_W'(s5_ay_ff) : map_y;
      end
      rsp_data_in = '0;
      if (finish) begin
         rsp_data_in.pressed         = 1'b1;
         rsp_data_in.pos_x           = new_x;
         rsp_data_in.pos_y           = new_y;
         rsp_data_in.press_x         = pen_held_ff ? down_x_ff : new_x;
         rsp_data_in.press_y         = pen_held_ff ? down_y_ff : new_y;
         rsp_data_in.readings_agreed = s5_agree_ff;
      end else begin
         // Pen-up scan: release when held, idle marker otherwise.
         rsp_data_in.pressed         = 1'b0;
         rsp_data_in.pos_x           = pen_held_ff ? cur_x_ff : POS_IDLE;
         rsp_data_in.pos_y           = pen_held_ff ? cur_y_ff : POS_IDLE;
         rsp_data_in.press_x         = pen_held_ff ? down_x_ff : '0;
         rsp_data_in.press_y         = pen_held_ff ? down_y_ff : '0;
         rsp_data_in.readings_agreed = 1'b0;
      end
   end

   // Touch state tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_held_ff <= 1'b0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         down_x_ff   <= '0;
         down_y_ff   <= '0;
      end else if (finish) begin
         cur_x_ff <= new_x;
         cur_y_ff <= new_y;
         if (!pen_held_ff) begin
            pen_held_ff <= 1'b1;
            down_x_ff   <= new_x;
            down_y_ff   <= new_y;
         end
      end else if (pen_up_fire) begin
         if (pen_held_ff) begin
            pen_held_ff <= 1'b0;
         end else begin
            cur_x_ff  <= POS_IDLE;
            cur_y_ff  <= POS_IDLE;
            down_x_ff <= '0;
            down_y_ff <= '0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish || pen_up_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish || pen_up_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
